>>> hw/rtl/i2c_master_bit_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// I2C master bit sequencer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define I2CBS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/i2cbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, micro-step opcodes, sequence programs and shared structs.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned CFG_W = 16;

  // Config register indexes
  localparam logic [1:0] REG_SHORT_DELAY = 2'd0;
  localparam logic [1:0] REG_LONG_DELAY  = 2'd1;
  localparam logic [1:0] REG_STRETCH     = 2'd2;

  // Command codes on mode
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // Micro-step opcodes
  typedef enum logic [3:0] {
    OP_END     = 4'd0,
    OP_WS      = 4'd1,
    OP_WL      = 4'd2,
    OP_SCL0    = 4'd3,
    OP_SCL1    = 4'd4,
    OP_SDA0    = 4'd5,
    OP_SDA1    = 4'd6,
    OP_BOTH0   = 4'd7,
    OP_BOTH1   = 4'd8,
    OP_SDABIT  = 4'd9,
    OP_SDAACK  = 4'd10,
    OP_SAMPACK = 4'd11,
    OP_SAMPBIT = 4'd12,
    OP_POLL    = 4'd13,
    OP_LOOP    = 4'd14
  } op_t;

  // Timing registers
  typedef struct packed {
    logic [CFG_W-1:0] short_delay;
    logic [CFG_W-1:0] long_delay;
    logic [CFG_W-1:0] stretch_polls;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic [3:0] stretch_timeouts;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_pull_low;
  } res_t;

  // Sequence programs: prog is command minus one, step is the program counter
  function automatic op_t prog_op(input logic [1:0] prog, input logic [3:0] step);
    op_t op;
    op = OP_END;
    unique case (prog)
      2'd0: begin  // start condition
        unique case (step)
          4'd0:    op = OP_BOTH1;
          4'd1:    op = OP_WS;
          4'd2:    op = OP_SDA0;
          4'd3:    op = OP_WL;
          4'd4:    op = OP_SCL0;
          4'd5:    op = OP_WS;
          default: op = OP_END;
        endcase
      end
      2'd1: begin  // stop condition
        unique case (step)
          4'd0:    op = OP_BOTH0;
          4'd1:    op = OP_WS;
          4'd2:    op = OP_SCL1;
          4'd3:    op = OP_WL;
          4'd4:    op = OP_SDA1;
          4'd5:    op = OP_WS;
          default: op = OP_END;
        endcase
      end
      2'd2: begin  // byte write
        unique case (step)
          4'd0:    op = OP_WS;
          4'd1:    op = OP_SDABIT;
          4'd2:    op = OP_WS;
          4'd3:    op = OP_SCL1;
          4'd4:    op = OP_WL;
          4'd5:    op = OP_SCL0;
          4'd6:    op = OP_LOOP;
          4'd7:    op = OP_WL;
          4'd8:    op = OP_SDA1;
          4'd9:    op = OP_SCL1;
          4'd10:   op = OP_WL;
          4'd11:   op = OP_SAMPACK;
          4'd12:   op = OP_SCL0;
          4'd13:   op = OP_WS;
          default: op = OP_END;
        endcase
      end
      default: begin  // byte read
        unique case (step)
          4'd0:    op = OP_WS;
          4'd1:    op = OP_SCL1;
          4'd2:    op = OP_WS;
          4'd3:    op = OP_POLL;
          4'd4:    op = OP_SAMPBIT;
          4'd5:    op = OP_SCL0;
          4'd6:    op = OP_LOOP;
          4'd7:    op = OP_WL;
          4'd8:    op = OP_SDAACK;
          4'd9:    op = OP_WS;
          4'd10:   op = OP_SCL1;
          4'd11:   op = OP_WL;
          4'd12:   op = OP_SCL0;
          4'd13:   op = OP_SDA1;
          4'd14:   op = OP_WL;
          default: op = OP_END;
        endcase
      end
    endcase
    return op;
  endfunction

endpackage

>>> hw/rtl/i2cbs_core.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Sequencer state; advances one micro-step per accepted tick unless a wait or
// poll step holds, and presents the post-tick result for the output register.
// ----------------------------------------------------------------------------
module i2cbs_core #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [2:0]       mode,
  input  logic [7:0]       tx_byte,
  input  logic             send_nack,
  input  logic             sda_in,
  input  logic             scl_in,
  input  i2cbs_pkg::cfg_t  cfg,
  output i2cbs_pkg::res_t  res_nxt
);
  import i2cbs_pkg::*;

  // compare width covers both the counter and the 16-bit registers
  localparam int unsigned CW = ((DELAY_WIDTH > CFG_W) ? DELAY_WIDTH : CFG_W) + 1;

  logic [3:0]             step_r, step_nxt;
  logic [2:0]             cmd_r, cmd_nxt;
  logic [3:0]             bit_r, bit_nxt;
  logic [DELAY_WIDTH-1:0] delay_r, delay_nxt;
  logic [CFG_W-1:0]       poll_r, poll_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   ack_r, ack_nxt;
  logic                   nack_r, nack_nxt;
  logic [3:0]             tmo_r, tmo_nxt;
  logic                   scl_lvl_r, scl_lvl_nxt;
  logic                   sda_lvl_r, sda_lvl_nxt;
  logic                   done;

  op_t                    op;
  logic [CFG_W-1:0]       wait_reg;
  logic [CW-1:0]          cnt_inc, reg_ext, dmax, eff;
  logic                   wait_done;
  logic [CFG_W:0]         poll_inc;

  // Current micro-step
  assign op = prog_op(2'(cmd_r - 3'd1), step_r);

  // Wait compare: saturate to counter max, zero acts as one
  assign wait_reg = (op == OP_WL) ? cfg.long_delay : cfg.short_delay;
  assign cnt_inc  = CW'(delay_r) + CW'(1);
  assign reg_ext  = CW'(wait_reg);
  assign dmax     = CW'({DELAY_WIDTH{1'b1}});
  always_comb begin
    eff = (reg_ext > dmax) ? dmax : reg_ext;
    if (eff == '0) begin
      eff = CW'(1);
    end
  end
  assign wait_done = (cnt_inc >= eff);
  assign poll_inc  = {1'b0, poll_r} + (CFG_W+1)'(1);

  // Next state
  always_comb begin
    step_nxt    = step_r;
    cmd_nxt     = cmd_r;
    bit_nxt     = bit_r;
    delay_nxt   = delay_r;
    poll_nxt    = poll_r;
    shift_nxt   = shift_r;
    rx_nxt      = rx_r;
    ack_nxt     = ack_r;
    nack_nxt    = nack_r;
    tmo_nxt     = tmo_r;
    scl_lvl_nxt = scl_lvl_r;
    sda_lvl_nxt = sda_lvl_r;
    done        = 1'b0;
    if (cmd_r == CMD_NONE) begin
      // idle: latch a valid command
      if (mode >= CMD_START && mode <= CMD_READ) begin
        cmd_nxt   = mode;
        step_nxt  = '0;
        bit_nxt   = '0;
        delay_nxt = '0;
        poll_nxt  = '0;
        shift_nxt = (mode == CMD_WRITE) ? tx_byte : 8'd0;
        ack_nxt   = send_nack;
        if (mode == CMD_READ) begin
          sda_lvl_nxt = 1'b1;
          tmo_nxt     = '0;
        end
      end
    end else begin
      step_nxt = step_r + 4'd1;
      case (op)
        OP_WS, OP_WL: begin
          delay_nxt = wait_done ? '0 : cnt_inc[DELAY_WIDTH-1:0];
          if (!wait_done) begin
            step_nxt = step_r;
          end
        end
        OP_SCL0:    scl_lvl_nxt = 1'b0;
        OP_SCL1:    scl_lvl_nxt = 1'b1;
        OP_SDA0:    sda_lvl_nxt = 1'b0;
        OP_SDA1:    sda_lvl_nxt = 1'b1;
        OP_BOTH0: begin
          scl_lvl_nxt = 1'b0;
          sda_lvl_nxt = 1'b0;
        end
        OP_BOTH1: begin
          scl_lvl_nxt = 1'b1;
          sda_lvl_nxt = 1'b1;
        end
        OP_SDABIT:  sda_lvl_nxt = shift_r[7];
        OP_SDAACK:  sda_lvl_nxt = ack_r;
        OP_SAMPACK: nack_nxt = sda_in;
        OP_SAMPBIT: shift_nxt = {shift_r[6:0], sda_in};
        OP_POLL: begin
          // clock stretch: short wait, then check SCL
          if (cfg.stretch_polls != '0) begin
            delay_nxt = wait_done ? '0 : cnt_inc[DELAY_WIDTH-1:0];
            if (!wait_done) begin
              step_nxt = step_r;
            end else if (scl_in) begin
              poll_nxt = '0;
            end else if (poll_inc[CFG_W-1:0] >= cfg.stretch_polls) begin
              poll_nxt = '0;
              if (tmo_r != 4'hF) begin
                tmo_nxt = tmo_r + 4'd1;
              end
            end else begin
              poll_nxt = poll_inc[CFG_W-1:0];
              step_nxt = step_r;
            end
          end
        end
        OP_LOOP: begin
          bit_nxt = bit_r + 4'd1;
          if (cmd_r == CMD_WRITE) begin
            shift_nxt = {shift_r[6:0], 1'b0};
          end
          if (bit_nxt < 4'd8) begin
            step_nxt = '0;
          end
        end
        default: begin
          // end of program
          if (cmd_r == CMD_READ) begin
            rx_nxt = shift_r;
          end
          cmd_nxt  = CMD_NONE;
          step_nxt = '0;
          done     = 1'b1;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      cmd_r     <= CMD_NONE;
      bit_r     <= '0;
      delay_r   <= '0;
      poll_r    <= '0;
      shift_r   <= '0;
      rx_r      <= '0;
      ack_r     <= 1'b0;
      nack_r    <= 1'b0;
      tmo_r     <= '0;
      scl_lvl_r <= 1'b1;
      sda_lvl_r <= 1'b1;
    end else if (step_en) begin
      step_r    <= step_nxt;
      cmd_r     <= cmd_nxt;
      bit_r     <= bit_nxt;
      delay_r   <= delay_nxt;
      poll_r    <= poll_nxt;
      shift_r   <= shift_nxt;
      rx_r      <= rx_nxt;
      ack_r     <= ack_nxt;
      nack_r    <= nack_nxt;
      tmo_r     <= tmo_nxt;
      scl_lvl_r <= scl_lvl_nxt;
      sda_lvl_r <= sda_lvl_nxt;
    end
  end

  // Result of this tick
  always_comb begin
    res_nxt.scl_pull_low     = ~scl_lvl_nxt;
    res_nxt.sda_pull_low     = ~sda_lvl_nxt;
    res_nxt.busy_res         = (cmd_nxt != CMD_NONE);
    res_nxt.done_res         = done;
    res_nxt.rx_byte          = rx_nxt;
    res_nxt.nack_seen        = nack_nxt;
    res_nxt.stretch_timeouts = tmo_nxt;
  end

endmodule

>>> hw/rtl/i2c_master_bit_sequencer_unit.sv
// Latency: a result item is valid the cycle after its tick item is accepted.
// Throughput: one tick item per cycle; in_tready drops only while a result
// waits in the output register and out_tready is low.
// Reset (rst_n low, synchronous): sequencer idle, both lines released,
// delays 5/10 ticks, 100 stretch polls, output register empty.
// ----------------------------------------------------------------------------
// I2C master bit sequencer unit
// Open-drain I2C master sequencer with stream input/output and config port.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2c_master_bit_sequencer_unit #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input ticks
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // tx_byte[7:0], send_nack[8], sda_in[9], scl_in[10], zero
  input  logic [2:0]  in_tuser,   // mode[2:0]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // scl_pull_low[0], sda_pull_low[1], busy_res[2],
                                  // done_res[3], rx_byte[11:4], nack_seen[12],
                                  // stretch_timeouts[16:13], zero
  // config writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [i2cbs_pkg::CFG_W-1:0] cfg_data
);
  import i2cbs_pkg::*;

  cfg_t  cfg_r;
  res_t  res_nxt;
  res_t  out_data_r;
  logic  out_valid_r;
  logic  in_fire;

  // Config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_delay   <= CFG_W'(5);
      cfg_r.long_delay    <= CFG_W'(10);
      cfg_r.stretch_polls <= CFG_W'(100);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHORT_DELAY: cfg_r.short_delay   <= cfg_data;
        REG_LONG_DELAY:  cfg_r.long_delay    <= cfg_data;
        REG_STRETCH:     cfg_r.stretch_polls <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: take a tick whenever the output slot is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  i2cbs_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_fire),
    .mode      (in_tuser),
    .tx_byte   (in_tdata[7:0]),
    .send_nack (in_tdata[8]),
    .sda_in    (in_tdata[9]),
    .scl_in    (in_tdata[10]),
    .cfg       (cfg_r),
    .res_nxt   (res_nxt)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

  // Checks
  `I2CBS_ASSERT_NEXT(a_fire_gives_result, in_fire, out_valid_r, "accepted tick gave no result")
  `I2CBS_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_tready, "not ready with empty output")
  `I2CBS_ASSERT_NOW(a_done_not_busy, out_valid_r, !(out_data_r.done_res && out_data_r.busy_res), "done while busy")
  `I2CBS_ASSERT_NOW(a_timeouts_bounded, out_valid_r, out_data_r.stretch_timeouts <= 4'd8, "too many stretch timeouts")

endmodule
